FILE: rtl/core/auto_range_normalizer_top_defines.svh
// auto_range_normalizer_top_defines.svh
// Assertion macros used at the end of the normalizer top level.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef AUTO_RANGE_NORMALIZER_TOP_DEFINES_SVH
`define AUTO_RANGE_NORMALIZER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define ANR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define ANR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/anr_pkg.sv
// anr_pkg.sv
// Shared widths, constants, register indexes and controller/datapath structs
// for the auto-ranging normalizer. No dependencies.
package anr_pkg;

    localparam int DATA_W     = 32;
    localparam int APB_W      = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int FRAC_W     = 17;
    localparam int LOG_F_W    = 16;
    localparam int LOG_W      = 22;
    localparam int NUM_W      = DATA_W + 2;
    localparam int Q_W        = 23;
    localparam int CNT_W      = 4;
    localparam int FRAC_BITS  = 16;

    localparam int NORM_STEPS = 5;
    localparam int SQ_STEPS   = LOG_F_W;
    localparam int DIV_STEPS  = FRAC_W - 1;

    localparam logic signed [DATA_W-1:0] RANGE_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] INT_MAX   = 32'sh7FFF_FFFF;
    localparam logic [FRAC_W-1:0]        FRAC_ONE  = 17'h1_0000;
    localparam logic [DATA_W-1:0]        ROUND_HALF = 32'd500;
    localparam logic [DATA_W-1:0]        THOUSAND   = 32'd1000;
    // floor(2^32 / 1000), reciprocal for the divide by one thousand
    localparam logic [Q_W-1:0]           RECIP_K    = 23'd4294967;

    typedef enum logic [2:0] {
        REG_LOG_MODE    = 3'd0,
        REG_SYMMETRIC   = 3'd1,
        REG_AUTO_ADJUST = 3'd2,
        REG_PRESET_MIN  = 3'd3,
        REG_PRESET_MAX  = 3'd4
    } anr_reg_idx_t;

    typedef enum logic [1:0] {
        LOG_OP_SAMPLE = 2'd0,
        LOG_OP_LOW    = 2'd1,
        LOG_OP_HIGH   = 2'd2
    } anr_log_op_t;

    typedef struct packed {
        logic        load_sample;
        logic        adjust;
        logic        repair;
        logic        commit;
        logic        log_load;
        logic        log_norm;
        logic        log_square;
        logic        log_store;
        logic        div_setup;
        logic        div_check;
        logic        div_step;
        logic        out_write;
        anr_log_op_t op;
        anr_log_op_t load_op;
        logic [2:0]  step;
    } anr_cmd_t;

    typedef struct packed {
        logic need_log;
        logic div_needed;
        logic out_free;
    } anr_sts_t;

endpackage

FILE: rtl/core/auto_range_normalizer_top.sv
// Auto-ranging normalizer, top level.
// Input channel in_valid/in_ready carries one signed Q16.16 sample per
// transaction; output channel out_valid/out_ready carries the Q1.16 fraction,
// the log flag, the empty flag and the range bounds after that sample.
// Settings are written over the APB-style port (pready always high); the
// user must write them only while the block is idle, which the block itself
// does not enforce. A preset write loads the range at once.
// One sample is in work at a time. The 16-step restoring divider runs only
// when a divide is needed; in log mode three log2 passes (five normalize
// steps, sixteen 32x32 squarings, one store) run ahead of it on the single
// shared squaring unit.
// A new sample is taken the cycle after the result is loaded into the output
// register, even while that result still waits for out_ready; if the previous
// result is still unread and out_ready is low when the next result is
// finished, the sequencer holds it until the register frees. Reset restores
// the default settings, marks the range empty and drops out_valid.
// Depends on anr_pkg, anr_ctrl, anr_dp and the assertion macro header.
`include "auto_range_normalizer_top_defines.svh"

module auto_range_normalizer_top
    import anr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FRAC_W-1:0]        fraction,
    output logic                     log_active,
    output logic                     range_empty,
    output logic signed [DATA_W-1:0] low_bound,
    output logic signed [DATA_W-1:0] high_bound,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [APB_W-1:0]         pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     pready
);

    anr_cmd_t cmd;
    anr_sts_t sts;

    assign pready = 1'b1;

    // Sequencer
    anr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    anr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .sample      (sample),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fraction    (fraction),
        .log_active  (log_active),
        .range_empty (range_empty),
        .low_bound   (low_bound),
        .high_bound  (high_bound)
    );

    `ANR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    `ANR_ASSERT_SAME(a_frac_max, out_valid, fraction <= FRAC_ONE, "fraction above one")
    `ANR_ASSERT_SAME(a_empty_zero, out_valid && range_empty, fraction == '0, "empty range fraction")
    `ANR_ASSERT_SAME(a_bound_order, out_valid && !range_empty, low_bound <= high_bound, "bounds out of order")

endmodule

FILE: rtl/core/anr_ctrl.sv
// anr_ctrl.sv
// Sequencer for the normalizer: range update, log2 passes, divide, output.
// Depends on anr_pkg.
module anr_ctrl
    import anr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  anr_sts_t sts,
    output anr_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_ADJ    = 12'b0000_0000_0010,
        ST_REP1   = 12'b0000_0000_0100,
        ST_REP2   = 12'b0000_0000_1000,
        ST_LCHK   = 12'b0000_0001_0000,
        ST_LNORM  = 12'b0000_0010_0000,
        ST_LSQ    = 12'b0000_0100_0000,
        ST_LSTORE = 12'b0000_1000_0000,
        ST_DSEL   = 12'b0001_0000_0000,
        ST_DCHK   = 12'b0010_0000_0000,
        ST_DIV    = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } anr_state_t;

    anr_state_t  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    anr_log_op_t op_reg, op_next;

    // Hold state, step counter and log operand index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            op_reg    <= LOG_OP_SAMPLE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

    // Advance through the sequence and issue datapath commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        cmd         = '0;
        cmd.op      = op_reg;
        cmd.load_op = LOG_OP_SAMPLE;
        cmd.step    = cnt_reg[2:0];
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                cmd.adjust = 1'b1;
                state_next = ST_REP1;
            end
            ST_REP1:
            begin
                cmd.repair = 1'b1;
                state_next = ST_REP2;
            end
            ST_REP2:
            begin
                cmd.commit = 1'b1;
                state_next = ST_LCHK;
            end
            ST_LCHK:
            begin
                if (sts.need_log)
                begin
                    cmd.log_load = 1'b1;
                    op_next      = LOG_OP_SAMPLE;
                    cnt_next     = '0;
                    state_next   = ST_LNORM;
                end
                else
                begin
                    state_next = ST_DSEL;
                end
            end
            ST_LNORM:
            begin
                cmd.log_norm = 1'b1;
                if (cnt_reg == CNT_W'(NORM_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_LSQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LSQ:
            begin
                cmd.log_square = 1'b1;
                if (cnt_reg == CNT_W'(SQ_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_LSTORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LSTORE:
            begin
                cmd.log_store = 1'b1;
                case (op_reg)
                    LOG_OP_SAMPLE:
                    begin
                        cmd.log_load = 1'b1;
                        cmd.load_op  = LOG_OP_LOW;
                        op_next      = LOG_OP_LOW;
                        state_next   = ST_LNORM;
                    end
                    LOG_OP_LOW:
                    begin
                        cmd.log_load = 1'b1;
                        cmd.load_op  = LOG_OP_HIGH;
                        op_next      = LOG_OP_HIGH;
                        state_next   = ST_LNORM;
                    end
                    default:
                    begin
                        state_next = ST_DSEL;
                    end
                endcase
            end
            ST_DSEL:
            begin
                cmd.div_setup = 1'b1;
                state_next    = ST_DCHK;
            end
            ST_DCHK:
            begin
                cmd.div_check = 1'b1;
                cnt_next      = '0;
                state_next    = sts.div_needed ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/anr_dp.sv
// anr_dp.sv
// Normalizer datapath: config registers, range tracking, bit-serial log2,
// restoring divider and output register. Depends on anr_pkg.
module anr_dp
    import anr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  anr_cmd_t                 cmd,
    output anr_sts_t                 sts,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [APB_W-1:0]         pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FRAC_W-1:0]        fraction,
    output logic                     log_active,
    output logic                     range_empty,
    output logic signed [DATA_W-1:0] low_bound,
    output logic signed [DATA_W-1:0] high_bound
);

    // Configuration and range state
    logic                     log_mode_reg, sym_reg, auto_reg;
    logic signed [DATA_W-1:0] pmin_reg, pmax_reg;
    logic signed [DATA_W-1:0] range_low_reg, range_high_reg;
    logic                     empty_reg, log_on_reg;

    // Per-transaction working registers
    logic signed [DATA_W-1:0] sample_reg;
    logic signed [DATA_W-1:0] wlo_reg, whi_reg, hrep_reg;
    logic                     wlog_reg;
    logic [DATA_W-1:0]        x_reg;
    logic [Q_W-1:0]           qe_reg;
    logic [DATA_W-1:0]        m_reg;
    logic [4:0]               s_reg;
    logic [LOG_F_W-1:0]       f_reg;
    logic                     lpos_reg;
    logic signed [LOG_W-1:0]  lg_v_reg, lg_lo_reg, lg_hi_reg;
    logic signed [NUM_W-1:0]  num_reg, den_reg;
    logic [NUM_W-1:0]         rem_reg;
    logic [FRAC_W-1:0]        frac_reg;

    // Output register
    logic                     out_valid_reg;
    logic [FRAC_W-1:0]        fraction_reg;
    logic                     log_active_reg, range_empty_reg;
    logic signed [DATA_W-1:0] low_bound_reg, high_bound_reg;

    logic                     cfg_wr;
    anr_reg_idx_t             cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = anr_reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    // Widen the range with the sample (plain or symmetric)
    logic signed [DATA_W:0]   v_x, abs_v, sat_v, abs_l, abs_h, mag_m, rl_x, rh_x;
    logic signed [DATA_W-1:0] adj_lo, adj_hi;
    logic                     adj_log;

    always_comb
    begin
        v_x     = (DATA_W+1)'(sample_reg);
        rl_x    = (DATA_W+1)'(range_low_reg);
        rh_x    = (DATA_W+1)'(range_high_reg);
        adj_log = log_on_reg & ~sample_reg[DATA_W-1];
        abs_v   = (v_x < 0) ? -v_x : v_x;
        sat_v   = (abs_v > (DATA_W+1)'(INT_MAX)) ? (DATA_W+1)'(INT_MAX) : abs_v;
        abs_l   = (rl_x < 0) ? -rl_x : rl_x;
        abs_h   = (rh_x < 0) ? -rh_x : rh_x;
        mag_m   = (abs_l > abs_h) ? abs_l : abs_h;
        if (sym_reg && !adj_log)
        begin
            if ((sat_v > mag_m) || empty_reg)
            begin
                adj_lo = DATA_W'(-sat_v);
                adj_hi = DATA_W'(sat_v);
            end
            else
            begin
                adj_lo = range_low_reg;
                adj_hi = range_high_reg;
            end
        end
        else
        begin
            adj_lo = (empty_reg || (sample_reg < range_low_reg)) ? sample_reg : range_low_reg;
            adj_hi = (empty_reg || (sample_reg > range_high_reg)) ? sample_reg : range_high_reg;
        end
        if (adj_lo > adj_hi)
        begin
            adj_lo = adj_hi;
        end
    end

    // Make the high bound positive for log mode and start low = high / 1000
    logic signed [DATA_W:0]   hi_x, hi_abs;
    logic signed [DATA_W-1:0] hrep;
    logic [DATA_W-1:0]        x_val;
    logic [DATA_W+Q_W-1:0]    prod;

    always_comb
    begin
        hi_x = (DATA_W+1)'(whi_reg);
        if (hi_x > 0)
        begin
            hi_abs = hi_x;
        end
        else if (hi_x < 0)
        begin
            hi_abs = -hi_x;
        end
        else
        begin
            hi_abs = (DATA_W+1)'(RANGE_ONE);
        end
        hrep  = (hi_abs > (DATA_W+1)'(INT_MAX)) ? INT_MAX : DATA_W'(hi_abs);
        x_val = DATA_W'(hrep) + ROUND_HALF;
        prod  = (DATA_W+Q_W)'(x_val) * (DATA_W+Q_W)'(RECIP_K);
    end

    // Correct the reciprocal estimate and pick the final low bound
    logic [DATA_W-1:0]        rem1k;
    logic [Q_W-1:0]           q_fix;
    logic signed [DATA_W-1:0] lo_fix, fin_lo, fin_hi;

    always_comb
    begin
        rem1k  = x_reg - (DATA_W'(qe_reg) * THOUSAND);
        q_fix  = (rem1k >= THOUSAND) ? qe_reg + 1'b1 : qe_reg;
        lo_fix = (q_fix == '0) ? DATA_W'(1) : DATA_W'(q_fix);
        fin_lo = wlo_reg;
        fin_hi = whi_reg;
        if (wlog_reg)
        begin
            fin_hi = hrep_reg;
            if ((wlo_reg <= 0) || (wlo_reg >= hrep_reg))
            begin
                fin_lo = lo_fix;
            end
        end
    end

    // Log2 unit: operand select, normalize step, squaring step, result
    logic signed [DATA_W-1:0] lg_opnd;
    logic [5:0]               nrm_amt;
    logic [DATA_W-1:0]        nrm_top;
    logic [2*DATA_W-1:0]      sq;
    logic [DATA_W:0]          sq_t;
    logic [6:0]               lg_int;
    logic signed [LOG_W-1:0]  lg_res;

    always_comb
    begin
        case (cmd.load_op)
            LOG_OP_LOW:  lg_opnd = range_low_reg;
            LOG_OP_HIGH: lg_opnd = range_high_reg;
            default:     lg_opnd = sample_reg;
        endcase
        nrm_amt = 6'(DATA_W / 2) >> cmd.step;
        nrm_top = m_reg >> (6'(DATA_W) - nrm_amt);
        sq      = (2*DATA_W)'(m_reg) * (2*DATA_W)'(m_reg);
        sq_t    = sq[2*DATA_W-1:DATA_W-1];
        lg_int  = 7'(DATA_W - 1) - 7'(s_reg) - 7'(FRAC_BITS);
        lg_res  = lpos_reg ? {lg_int[5:0], f_reg} : '0;
    end

    // Choose numerator and denominator, fold the sign into the numerator
    logic signed [NUM_W-1:0] sel_num, sel_den;

    always_comb
    begin
        sel_num = '0;
        sel_den = NUM_W'(1);
        if (!empty_reg)
        begin
            if (!log_on_reg)
            begin
                sel_num = NUM_W'(sample_reg) - NUM_W'(range_low_reg);
                sel_den = NUM_W'(range_high_reg) - NUM_W'(range_low_reg);
            end
            else if (sample_reg > range_low_reg)
            begin
                sel_num = NUM_W'(lg_v_reg) - NUM_W'(lg_lo_reg);
                sel_den = NUM_W'(lg_hi_reg) - NUM_W'(lg_lo_reg);
            end
        end
        if (sel_den < 0)
        begin
            sel_num = -sel_num;
            sel_den = -sel_den;
        end
    end

    // Restoring divide step
    logic [NUM_W:0] div_r2, div_d;
    logic           div_ge;

    always_comb
    begin
        div_r2 = {rem_reg, 1'b0};
        div_d  = {1'b0, NUM_W'(den_reg)};
        div_ge = div_r2 >= div_d;
    end

    assign sts.need_log   = log_on_reg & ~empty_reg & (sample_reg > range_low_reg);
    assign sts.div_needed = (den_reg != 0) && (num_reg > 0) && (num_reg < den_reg);
    assign sts.out_free   = ~out_valid_reg | out_ready;

    // Hold configuration and range state; apply writes and commits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_mode_reg   <= 1'b0;
            sym_reg        <= 1'b0;
            auto_reg       <= 1'b1;
            pmin_reg       <= RANGE_ONE;
            pmax_reg       <= '0;
            range_low_reg  <= RANGE_ONE;
            range_high_reg <= '0;
            empty_reg      <= 1'b1;
            log_on_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.commit && auto_reg)
            begin
                range_low_reg  <= fin_lo;
                range_high_reg <= fin_hi;
                empty_reg      <= 1'b0;
                log_on_reg     <= wlog_reg;
            end
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_LOG_MODE:
                    begin
                        log_mode_reg <= pwdata[0];
                        log_on_reg   <= pwdata[0];
                    end
                    REG_SYMMETRIC:   sym_reg  <= pwdata[0];
                    REG_AUTO_ADJUST: auto_reg <= pwdata[0];
                    REG_PRESET_MIN:
                    begin
                        pmin_reg       <= DATA_W'(pwdata);
                        range_low_reg  <= DATA_W'(pwdata);
                        range_high_reg <= pmax_reg;
                        empty_reg      <= $signed(DATA_W'(pwdata)) > pmax_reg;
                        if (!($signed(DATA_W'(pwdata)) > pmax_reg))
                        begin
                            auto_reg <= 1'b0;
                        end
                    end
                    REG_PRESET_MAX:
                    begin
                        pmax_reg       <= DATA_W'(pwdata);
                        range_low_reg  <= pmin_reg;
                        range_high_reg <= DATA_W'(pwdata);
                        empty_reg      <= pmin_reg > $signed(DATA_W'(pwdata));
                        if (!(pmin_reg > $signed(DATA_W'(pwdata))))
                        begin
                            auto_reg <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Return register contents on reads
    always_comb
    begin
        unique case (cfg_idx)
            REG_LOG_MODE:    prdata = APB_W'(log_mode_reg);
            REG_SYMMETRIC:   prdata = APB_W'(sym_reg);
            REG_AUTO_ADJUST: prdata = APB_W'(auto_reg);
            REG_PRESET_MIN:  prdata = pmin_reg;
            REG_PRESET_MAX:  prdata = pmax_reg;
            default:         prdata = '0;
        endcase
    end

    // Working registers of the range update, log2 unit and divider
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sample;
        end
        if (cmd.adjust)
        begin
            wlo_reg  <= adj_lo;
            whi_reg  <= adj_hi;
            wlog_reg <= adj_log;
        end
        if (cmd.repair)
        begin
            hrep_reg <= hrep;
            x_reg    <= x_val;
            qe_reg   <= prod[DATA_W +: Q_W];
        end
        if (cmd.log_load)
        begin
            m_reg    <= DATA_W'(lg_opnd);
            s_reg    <= '0;
            f_reg    <= '0;
            lpos_reg <= lg_opnd > 0;
        end
        else if (cmd.log_norm)
        begin
            if (nrm_top == '0)
            begin
                m_reg <= m_reg << nrm_amt;
                s_reg <= s_reg + 5'(nrm_amt);
            end
        end
        else if (cmd.log_square)
        begin
            if (sq_t[DATA_W])
            begin
                m_reg <= sq_t[DATA_W:1];
                f_reg <= {f_reg[LOG_F_W-2:0], 1'b1};
            end
            else
            begin
                m_reg <= sq_t[DATA_W-1:0];
                f_reg <= {f_reg[LOG_F_W-2:0], 1'b0};
            end
        end
        if (cmd.log_store)
        begin
            case (cmd.op)
                LOG_OP_SAMPLE: lg_v_reg  <= lg_res;
                LOG_OP_LOW:    lg_lo_reg <= lg_res;
                LOG_OP_HIGH:   lg_hi_reg <= lg_res;
                default:
                begin
                end
            endcase
        end
        if (cmd.div_setup)
        begin
            num_reg <= sel_num;
            den_reg <= sel_den;
        end
        if (cmd.div_check)
        begin
            rem_reg <= NUM_W'(num_reg);
            if (den_reg == 0)
            begin
                frac_reg <= (num_reg > 0) ? FRAC_ONE : '0;
            end
            else if (num_reg <= 0)
            begin
                frac_reg <= '0;
            end
            else if (num_reg >= den_reg)
            begin
                frac_reg <= FRAC_ONE;
            end
            else
            begin
                frac_reg <= '0;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? NUM_W'(div_r2 - div_d) : NUM_W'(div_r2);
            frac_reg <= {frac_reg[FRAC_W-2:0], div_ge};
        end
    end

    // Output register: load on write, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_write)
        begin
            fraction_reg    <= frac_reg;
            log_active_reg  <= log_on_reg;
            range_empty_reg <= empty_reg;
            low_bound_reg   <= range_low_reg;
            high_bound_reg  <= range_high_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fraction    = fraction_reg;
    assign log_active  = log_active_reg;
    assign range_empty = range_empty_reg;
    assign low_bound   = low_bound_reg;
    assign high_bound  = high_bound_reg;

endmodule
